@@ src/clm_pkg.sv @@
// Shared types and constants of the colour-to-label matcher.
`default_nettype none
package clm_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CH_W        = 8;
  localparam int SQ_W        = 2 * CH_W;
  localparam int DIST_W      = 18;
  localparam int THR_W       = 18;
  localparam int LABEL_W     = 8;
  localparam int OP_W        = 2;

  localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd0;
  localparam logic [OP_W-1:0] OP_PRELOAD  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

  // Red in the top byte, blue in the bottom byte.
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // Table read in flight toward the distance unit.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } rd_tag_t;

  // Distance of one table entry to the current pixel.
  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] sq_dist;
  } score_t;

endpackage
`default_nettype wire

@@ src/clm_table_ram.sv @@
// Colour table storage: one write port, one read port, registered read data.
`default_nettype none
module clm_table_ram (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [clm_pkg::IDX_W-1:0] waddr,
  input  wire clm_pkg::rgb_t         wdata,
  input  wire logic [clm_pkg::IDX_W-1:0] raddr,
  output clm_pkg::rgb_t              rdata
);
  import clm_pkg::*;

  rgb_t mem [TABLE_DEPTH];
  rgb_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ src/clm_dist.sv @@
// Squared colour distance of one table entry per cycle, squares registered.
`default_nettype none
module clm_dist (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             flush,
  input  wire clm_pkg::rgb_t    pixel,
  input  wire clm_pkg::rgb_t    entry,
  input  wire clm_pkg::rd_tag_t tag,
  output clm_pkg::score_t       score
);
  import clm_pkg::*;

  logic             valid_r;
  logic [IDX_W-1:0] idx_r;
  logic [SQ_W-1:0]  sq_r_r, sq_g_r, sq_b_r;
  logic [CH_W-1:0]  d_red, d_green, d_blue;

  function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    d_red   = abs_diff(pixel.red,   entry.red);
    d_green = abs_diff(pixel.green, entry.green);
    d_blue  = abs_diff(pixel.blue,  entry.blue);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= tag.valid;
    end
    idx_r  <= tag.idx;
    sq_r_r <= SQ_W'(d_red) * SQ_W'(d_red);
    sq_g_r <= SQ_W'(d_green) * SQ_W'(d_green);
    sq_b_r <= SQ_W'(d_blue) * SQ_W'(d_blue);
  end

  always_comb begin
    score.valid   = valid_r;
    score.idx     = idx_r;
    score.sq_dist = DIST_W'(sq_r_r) + DIST_W'(sq_g_r) + DIST_W'(sq_b_r);
  end

endmodule
`default_nettype wire

@@ src/colour_to_label_matcher.sv @@
// Top level of the colour-to-label matcher: sequencer, entry count, result register.
//
// Input channel (in_valid/in_ready): one transaction per opcode, to classify a
//   pixel, preload a colour entry or clear the table. Each input transaction
//   yields one output transaction (out_valid/out_ready) with label, is_new and
//   table_full. cfg_wr_en/cfg_wr_data write the squared distance threshold;
//   write it only while no transaction is in flight.
// Timing: classify scans the table from entry 0, one memory read per cycle.
//   Read, squaring and compare follow in a pipeline; a match ends the scan at
//   the lowest matching entry, and a miss over N entries ends it when the
//   score of entry N-1 arrives. Preload, clear, reserved opcodes and classify
//   on an empty table skip the scan and go straight to the result.
// Throughput: one transaction at a time; in_ready rises with the result, so
//   a new item is taken only after the last result enters the output register.
// Reset: rst_n (synchronous, active low) empties the table (entry count 0) and
//   zeroes the threshold. Table contents are not cleared; only entries below
//   the entry count are read, so stale data is never seen.
// Stall: a result waiting in the output register leaves the input open; the
//   next finished result holds inside and closes the input until it moves out.
`default_nettype none
module colour_to_label_matcher (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [clm_pkg::OP_W-1:0]    in_opcode,
  input  wire logic [clm_pkg::CH_W-1:0]    in_red,
  input  wire logic [clm_pkg::CH_W-1:0]    in_green,
  input  wire logic [clm_pkg::CH_W-1:0]    in_blue,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [clm_pkg::LABEL_W-1:0]      out_label,
  output logic                             out_is_new,
  output logic                             out_table_full,
  input  wire logic                        cfg_wr_en,
  input  wire logic [clm_pkg::THR_W-1:0]   cfg_wr_data
);
  import clm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   issue_idx_r, issue_idx_nxt;
  rd_tag_t            rd_tag_r, rd_tag_nxt;
  logic [THR_W-1:0]   thr_r;
  rgb_t               pix_r, pix_nxt;

  logic [LABEL_W-1:0] res_label_r, res_label_nxt;
  logic               res_new_r, res_new_nxt;
  logic               res_full_r, res_full_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [LABEL_W-1:0] out_label_r;
  logic               out_is_new_r, out_table_full_r;
  logic               out_load;

  logic               in_fire;
  rgb_t               in_pixel, app_colour;
  logic               app_go, scan_flush;
  logic               tbl_we;
  logic [IDX_W-1:0]   tbl_waddr, tbl_raddr;
  rgb_t               tbl_rdata;
  score_t             score;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign in_pixel = '{red: in_red, green: in_green, blue: in_blue};

  // Appended colour: straight from the ports on acceptance, else the held pixel.
  assign app_colour = (state_r == ST_SCAN) ? pix_r : in_pixel;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    issue_idx_nxt = issue_idx_r;
    rd_tag_nxt    = '{valid: 1'b0, idx: issue_idx_r[IDX_W-1:0]};
    pix_nxt       = pix_r;
    res_label_nxt = res_label_r;
    res_new_nxt   = res_new_r;
    res_full_nxt  = res_full_r;
    app_go        = 1'b0;
    scan_flush    = 1'b0;
    out_load      = 1'b0;
    tbl_raddr     = issue_idx_r[IDX_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          pix_nxt       = in_pixel;
          res_label_nxt = '0;
          res_new_nxt   = 1'b0;
          res_full_nxt  = 1'b0;
          state_nxt     = ST_DONE;
          case (in_opcode)
            OP_CLASSIFY: begin
              if (count_r == '0) begin
                app_go = 1'b1;
              end else begin
                issue_idx_nxt = '0;
                state_nxt     = ST_SCAN;
              end
            end
            OP_PRELOAD: begin
              app_go = 1'b1;
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              // reserved opcode: no state change, all-zero result
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Issue one table read per cycle until every valid entry is out.
        if (issue_idx_r < count_r) begin
          rd_tag_nxt.valid = 1'b1;
          issue_idx_nxt    = issue_idx_r + CNT_W'(1);
        end
        // Reads return in order, so the first hit seen is the lowest index.
        if (score.valid && (score.sq_dist <= DIST_W'(thr_r))) begin
          res_label_nxt = LABEL_W'(score.idx);
          scan_flush    = 1'b1;
          rd_tag_nxt    = '0;
          state_nxt     = ST_DONE;
        end else if (score.valid && ({1'b0, score.idx} == CNT_W'(count_r - CNT_W'(1)))) begin
          app_go     = 1'b1;
          scan_flush = 1'b1;
          rd_tag_nxt = '0;
          state_nxt  = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold the result until the output register frees up.
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Append at the current count, or flag a full table.
    tbl_we    = 1'b0;
    tbl_waddr = count_r[IDX_W-1:0];
    if (app_go) begin
      if (count_r == CNT_W'(TABLE_DEPTH)) begin
        res_label_nxt = '0;
        res_full_nxt  = 1'b1;
      end else begin
        tbl_we        = 1'b1;
        res_label_nxt = LABEL_W'(count_r);
        res_new_nxt   = 1'b1;
        count_nxt     = count_r + CNT_W'(1);
      end
    end
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      issue_idx_r <= '0;
      rd_tag_r    <= '0;
      thr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_idx_r <= issue_idx_nxt;
      rd_tag_r    <= rd_tag_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pix_r       <= pix_nxt;
    res_label_r <= res_label_nxt;
    res_new_r   <= res_new_nxt;
    res_full_r  <= res_full_nxt;
    if (out_load) begin
      out_label_r      <= res_label_r;
      out_is_new_r     <= res_new_r;
      out_table_full_r <= res_full_r;
    end
  end

  clm_table_ram u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (app_colour),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  clm_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .flush (scan_flush),
    .pixel (pix_r),
    .entry (tbl_rdata),
    .tag   (rd_tag_r),
    .score (score)
  );

  assign out_valid      = out_valid_r;
  assign out_label      = out_label_r;
  assign out_is_new     = out_is_new_r;
  assign out_table_full = out_table_full_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_append_counts: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("table write without count advance");

  a_new_xor_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_is_new_r && out_table_full_r))
    else $error("result both new and full");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (issue_idx_r <= count_r))
    else $error("scan read past entry count");

  a_no_read_outside_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_SCAN) |-> !score.valid)
    else $error("distance result outside a scan");

endmodule
`default_nettype wire
